// ===== hdl/rsie_pkg.sv =====
// Shared types, constants and helpers of the RISC subset execute unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rsie_pkg;

    // Words of data store behind each base register (power of two).
    localparam int WORDS_PER_BASE = 1024;
    localparam int IDX_W          = $clog2(WORDS_PER_BASE);
    localparam int ADDR_W         = IDX_W + 4;
    localparam int STORE_DEPTH    = 16 * WORDS_PER_BASE;
    localparam int QDEPTH         = 2;
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    localparam logic [1:0] FMT_DATA   = 2'd0;
    localparam logic [1:0] FMT_MEM    = 2'd1;
    localparam logic [1:0] FMT_BRANCH = 2'd2;
    localparam logic [1:0] FMT_HALT   = 2'd3;

    localparam logic [3:0] OP_AND  = 4'd0;
    localparam logic [3:0] OP_XOR  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_RSB  = 4'd3;
    localparam logic [3:0] OP_ADD  = 4'd4;
    localparam logic [3:0] OP_ADC  = 4'd5;
    localparam logic [3:0] OP_SBC  = 4'd6;
    localparam logic [3:0] OP_RSC  = 4'd7;
    localparam logic [3:0] OP_CMP  = 4'd10;
    localparam logic [3:0] OP_ORR  = 4'd12;
    localparam logic [3:0] OP_MOV  = 4'd13;
    localparam logic [3:0] OP_BIC  = 4'd14;
    localparam logic [3:0] OP_MVN  = 4'd15;

    localparam logic [5:0] MEM_LDR = 6'd25;
    localparam logic [5:0] MEM_STR = 6'd24;
    localparam logic [1:0] BR_CODE = 2'd2;

    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    localparam logic [3:0] PC_INDEX = 4'd15;

    typedef enum logic [2:0] {
        KIND_ALU,
        KIND_CMP,
        KIND_LDR,
        KIND_STR,
        KIND_NOP,
        KIND_BR,
        KIND_HALT
    } kind_t;

    // Decoded instruction handed from the front end to the back end.
    typedef struct packed {
        kind_t            kind;
        logic [3:0]       alu_op;
        logic             use_imm;
        logic [3:0]       cond;
        logic [3:0]       rn;
        logic [3:0]       rb;
        logic [3:0]       rd;
        logic [7:0]       imm8;
        logic [IDX_W-1:0] idx;
        logic [23:0]      br_off;
    } uop_t;

    // Word index offset/4 wrapped to WORDS_PER_BASE words.
    function automatic logic [IDX_W-1:0] mem_index(input logic [9:0] q);
        logic [IDX_W+9:0] ext;
        ext = {{IDX_W{1'b0}}, q};
        return ext[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rsie_front.sv =====
// Front end: decodes instruction words and buffers them in a short queue.
// Depends on rsie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsie_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          hold,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [31:0]   s_instr_word,
    output logic               deq_valid,
    output rsie_pkg::uop_t     deq_uop,
    input  wire logic          deq_ready
);
    import rsie_pkg::*;

    uop_t              dec;
    uop_t              slot_reg [QDEPTH];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    always_comb begin
        dec         = '0;
        dec.alu_op  = s_instr_word[24:21];
        dec.use_imm = s_instr_word[25];
        dec.cond    = s_instr_word[31:28];
        dec.rn      = s_instr_word[19:16];
        dec.rd      = s_instr_word[15:12];
        dec.imm8    = s_instr_word[7:0];
        dec.idx     = mem_index(s_instr_word[11:2]);
        dec.br_off  = s_instr_word[23:0];
        dec.kind    = KIND_NOP;
        dec.rb      = s_instr_word[3:0];
        case (s_instr_word[27:26])
            FMT_DATA: begin
                dec.kind = (s_instr_word[24:21] == OP_CMP) ? KIND_CMP : KIND_ALU;
            end
            FMT_MEM: begin
                // A store reads the source register on the second port.
                dec.rb = s_instr_word[15:12];
                if (s_instr_word[25:20] == MEM_LDR) begin
                    dec.kind = KIND_LDR;
                end else if (s_instr_word[25:20] == MEM_STR) begin
                    dec.kind = KIND_STR;
                end
            end
            FMT_BRANCH: begin
                if (s_instr_word[25:24] == BR_CODE) begin
                    dec.kind = KIND_BR;
                end
            end
            default: begin
                dec.kind = KIND_HALT;
            end
        endcase
    end

    assign s_ready   = !hold && (count_reg != QCNT_W'(QDEPTH));
    assign push      = s_valid && s_ready;
    assign deq_valid = (count_reg != '0);
    assign pop       = deq_valid && deq_ready;
    assign deq_uop   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rsie_back.sv =====
// Back end: operand read, execute and commit, data store, result register.
// Depends on rsie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsie_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          deq_valid,
    input  rsie_pkg::uop_t     deq_uop,
    output logic               deq_ready,
    output logic               clearing,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [31:0]        m_next_pc,
    output logic               m_reg_write,
    output logic [3:0]         m_reg_index,
    output logic [31:0]        m_reg_value,
    output logic               m_store_write,
    output logic               m_halted
);
    import rsie_pkg::*;

    logic [31:0]       rf_mem [16];
    logic [15:0]       rf_valid_reg;
    logic [31:0]       store_mem [STORE_DEPTH];
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clr_busy_reg;

    logic        e_valid_reg;
    uop_t        e_uop_reg;
    logic [31:0] opa_reg;
    logic [31:0] opb_reg;
    logic        a_pc_reg;
    logic        b_pc_reg;
    logic [31:0] mem_rdata_reg;
    logic        ld_hit_reg;
    logic [31:0] ld_byp_reg;

    logic [31:0] pc_reg;
    logic        less_reg;
    logic        equal_reg;
    logic        halt_mark_reg;

    logic        out_valid_reg;
    logic [31:0] out_pc_reg;
    logic        out_wr_reg;
    logic [3:0]  out_idx_reg;
    logic [31:0] out_val_reg;
    logic        out_st_reg;
    logic        out_hl_reg;

    logic              adv;
    logic              load;
    logic              commit;
    logic [31:0]       pc_adv;
    logic [31:0]       a;
    logic [31:0]       rb_val;
    logic [31:0]       b;
    logic [31:0]       alu_val;
    logic [31:0]       ld_val;
    logic              taken;
    logic              wr;
    logic              st;
    logic              hl;
    logic [31:0]       val;
    logic [31:0]       pc_next;
    logic              less_next;
    logic              equal_next;
    logic [ADDR_W-1:0] st_addr;
    logic [ADDR_W-1:0] head_addr;
    logic              rf_we;

    assign adv       = !out_valid_reg || m_ready;
    assign deq_ready = adv && !clr_busy_reg;
    assign load      = deq_ready && deq_valid;
    assign commit    = adv && e_valid_reg && !halt_mark_reg;
    assign clearing  = clr_busy_reg;

    assign pc_adv    = pc_reg + 32'd4;
    assign a         = a_pc_reg ? pc_adv : opa_reg;
    assign rb_val    = b_pc_reg ? pc_adv : opb_reg;
    assign b         = e_uop_reg.use_imm ? {24'd0, e_uop_reg.imm8} : rb_val;
    assign ld_val    = ld_hit_reg ? ld_byp_reg : mem_rdata_reg;
    assign st_addr   = {e_uop_reg.rn, e_uop_reg.idx};
    assign head_addr = {deq_uop.rn, deq_uop.idx};

    always_comb begin
        case (e_uop_reg.alu_op)
            OP_AND:  alu_val = a & b;
            OP_XOR:  alu_val = a ^ b;
            OP_SUB:  alu_val = a - b;
            OP_RSB:  alu_val = b - a;
            OP_ADD:  alu_val = a + b;
            OP_ADC:  alu_val = a + b;
            OP_SBC:  alu_val = a - b;
            OP_RSC:  alu_val = b - a;
            OP_ORR:  alu_val = a | b;
            OP_MOV:  alu_val = b;
            OP_BIC:  alu_val = a & ~b;
            OP_MVN:  alu_val = ~b;
            default: alu_val = 32'd0;
        endcase
    end

    always_comb begin
        case (e_uop_reg.cond)
            COND_EQ: taken = equal_reg;
            COND_NE: taken = !equal_reg;
            COND_GE: taken = equal_reg || !less_reg;
            COND_LT: taken = less_reg && !equal_reg;
            COND_GT: taken = !less_reg && !equal_reg;
            COND_LE: taken = equal_reg || less_reg;
            COND_AL: taken = 1'b1;
            default: taken = 1'b0;
        endcase
    end

    always_comb begin
        wr         = 1'b0;
        st         = 1'b0;
        hl         = 1'b0;
        val        = 32'd0;
        pc_next    = pc_adv;
        less_next  = less_reg;
        equal_next = equal_reg;
        if (halt_mark_reg) begin
            hl      = 1'b1;
            pc_next = pc_reg;
        end else begin
            case (e_uop_reg.kind)
                KIND_ALU: begin
                    wr  = 1'b1;
                    val = alu_val;
                end
                KIND_CMP: begin
                    less_next  = e_uop_reg.use_imm ? (a < b) : ($signed(a) < $signed(b));
                    equal_next = (a == b);
                end
                KIND_LDR: begin
                    wr  = 1'b1;
                    val = ld_val;
                end
                KIND_STR: begin
                    st = 1'b1;
                end
                KIND_BR: begin
                    if (taken) begin
                        pc_next = pc_adv + 32'd4
                                + {{6{e_uop_reg.br_off[23]}}, e_uop_reg.br_off, 2'b00};
                    end
                end
                KIND_HALT: begin
                    hl = 1'b1;
                end
                default: begin
                end
            endcase
            if (wr && (e_uop_reg.rd == PC_INDEX)) begin
                pc_next = val;
            end
        end
    end

    assign rf_we = commit && wr && (e_uop_reg.rd != PC_INDEX);

    // Register file: two registered read ports with bypass of the commit.
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[e_uop_reg.rd] <= val;
        end
        if (adv) begin
            if (rf_we && (e_uop_reg.rd == deq_uop.rn)) begin
                opa_reg <= val;
            end else begin
                opa_reg <= rf_valid_reg[deq_uop.rn] ? rf_mem[deq_uop.rn] : 32'd0;
            end
            if (rf_we && (e_uop_reg.rd == deq_uop.rb)) begin
                opb_reg <= val;
            end else begin
                opb_reg <= rf_valid_reg[deq_uop.rb] ? rf_mem[deq_uop.rb] : 32'd0;
            end
            a_pc_reg  <= (deq_uop.rn == PC_INDEX);
            b_pc_reg  <= (deq_uop.rb == PC_INDEX);
            e_uop_reg <= deq_uop;
        end
    end

    // Data store: one write port (clear or store), one registered read port.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            store_mem[clr_cnt_reg] <= 32'd0;
        end else if (commit && st) begin
            store_mem[st_addr] <= rb_val;
        end
        if (adv) begin
            mem_rdata_reg <= store_mem[head_addr];
            ld_hit_reg    <= commit && st && (st_addr == head_addr);
            ld_byp_reg    <= rb_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            rf_valid_reg  <= '0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= 32'd0;
            less_reg      <= 1'b0;
            equal_reg     <= 1'b0;
            halt_mark_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (rf_we) begin
                rf_valid_reg[e_uop_reg.rd] <= 1'b1;
            end
            if (adv) begin
                e_valid_reg   <= load;
                out_valid_reg <= e_valid_reg;
            end
            if (commit) begin
                pc_reg    <= pc_next;
                less_reg  <= less_next;
                equal_reg <= equal_next;
                if (e_uop_reg.kind == KIND_HALT) begin
                    halt_mark_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_pc_reg  <= pc_next;
            out_wr_reg  <= wr;
            out_idx_reg <= wr ? e_uop_reg.rd : 4'd0;
            out_val_reg <= val;
            out_st_reg  <= st;
            out_hl_reg  <= hl;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_next_pc     = out_pc_reg;
    assign m_reg_write   = out_wr_reg;
    assign m_reg_index   = out_idx_reg;
    assign m_reg_value   = out_val_reg;
    assign m_store_write = out_st_reg;
    assign m_halted      = out_hl_reg;

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_mark_reg |=> halt_mark_reg)
        else $error("halt mark dropped");

    a_no_exec_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !e_valid_reg && !out_valid_reg)
        else $error("instruction in flight during store clear");

    a_halted_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_hl_reg |-> !out_wr_reg && !out_st_reg)
        else $error("halted word performed a write");

    a_pc_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_mark_reg && $past(halt_mark_reg) |-> $stable(pc_reg))
        else $error("counter moved while halted");

endmodule

`default_nettype wire

// ===== hdl/risc_subset_instruction_execute_unit.sv =====
// Top level of the RISC subset execute unit: front-end decode queue and
// back-end execute. Depends on rsie_pkg, rsie_front and rsie_back.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// The input channel (s_valid, s_ready, s_instr_word) takes one instruction
// word per handshake, the word fetched at the previous m_next_pc. The result
// channel (m_valid, m_ready, m_*) returns one word per instruction, in order:
// the new program counter, the register write if any, a store flag and halt.
// Throughput is one instruction per cycle while m_ready stays high and no
// store sweep runs. From the input handshake a word passes the decode queue,
// then the operand registers of the register file and data store that feed
// execute and commit, after which the result register holds the word.
// Operand dependences are resolved by bypassing the committing result into
// the read registers, so back-to-back dependent instructions do not stall.
// After reset the data store is swept to zero, one entry per cycle, over all
// 16 * WORDS_PER_BASE entries (16384 at the default size); s_ready
// stays low during the sweep. When the receiver holds m_ready low, the
// execute stage freezes, the two-entry queue fills and s_ready then drops.
// After a halt instruction every later word returns halted with the counter
// unchanged and no writes.

module risc_subset_instruction_execute_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_instr_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_next_pc,
    output logic             m_reg_write,
    output logic [3:0]       m_reg_index,
    output logic [31:0]      m_reg_value,
    output logic             m_store_write,
    output logic             m_halted
);
    import rsie_pkg::*;

    // Decoded words flow from the queue head into the back end.
    uop_t deq_uop;
    logic deq_valid;
    logic deq_ready;
    logic clearing;

    rsie_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .hold         (clearing),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_instr_word (s_instr_word),
        .deq_valid    (deq_valid),
        .deq_uop      (deq_uop),
        .deq_ready    (deq_ready)
    );

    // The back end owns all architectural state and the result register.
    rsie_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .deq_valid     (deq_valid),
        .deq_uop       (deq_uop),
        .deq_ready     (deq_ready),
        .clearing      (clearing),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_pc     (m_next_pc),
        .m_reg_write   (m_reg_write),
        .m_reg_index   (m_reg_index),
        .m_reg_value   (m_reg_value),
        .m_store_write (m_store_write),
        .m_halted      (m_halted)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the RISC subset execute unit: directed words, then
// random instruction streams and a halt, checked against a behavioral predictor.
// Depends on rsie_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;
    import rsie_pkg::*;

    // Clock and reset.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_instr_word = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_next_pc;
    logic        m_reg_write;
    logic [3:0]  m_reg_index;
    logic [31:0] m_reg_value;
    logic        m_store_write;
    logic        m_halted;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    risc_subset_instruction_execute_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_instr_word(s_instr_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_next_pc(m_next_pc),
        .m_reg_write(m_reg_write), .m_reg_index(m_reg_index),
        .m_reg_value(m_reg_value), .m_store_write(m_store_write),
        .m_halted(m_halted)
    );

    // One retired instruction as seen on the result channel.
    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic        store_write;
        logic        halted;
    } retire_t;

    // Architectural state mirrored by the predictor.
    logic [31:0] regs [16];
    logic        lt_flag, eq_flag, stopped;
    logic [31:0] mem [16][WORDS_PER_BASE];

    retire_t retire_q[$];
    int      errors = 0;
    int      stall_cycles = 0;
    int      send_idle = 0;   // sender idle percentage
    int      recv_idle = 0;   // receiver idle percentage

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic cond_holds(input logic [3:0] c);
        case (c)
            COND_EQ: return eq_flag;
            COND_NE: return !eq_flag;
            COND_GE: return eq_flag || !lt_flag;
            COND_LT: return lt_flag && !eq_flag;
            COND_GT: return !lt_flag && !eq_flag;
            COND_LE: return eq_flag || lt_flag;
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Executes one word on the mirrored state and returns its retire word.
    function automatic retire_t execute_word(input logic [31:0] w);
        retire_t     r;
        logic [3:0]  rn, rd, op;
        logic [31:0] a, b, v, off;
        logic [IDX_W-1:0] ix;
        r = '0;
        rn = w[19:16];
        rd = w[15:12];
        if (stopped) begin
            r.halted = 1'b1;
        end else begin
            regs[PC_INDEX] = regs[PC_INDEX] + 32'd4;
            v = 32'd0;
            case (w[27:26])
                FMT_DATA: begin
                    op = w[24:21];
                    a = regs[rn];
                    b = w[25] ? {24'd0, w[7:0]} : regs[w[3:0]];
                    if (op == OP_CMP) begin
                        lt_flag = w[25] ? (a < b) : ($signed(a) < $signed(b));
                        eq_flag = (a == b);
                    end else begin
                        case (op)
                            OP_AND: v = a & b;
                            OP_XOR: v = a ^ b;
                            OP_SUB, OP_SBC: v = a - b;
                            OP_RSB, OP_RSC: v = b - a;
                            OP_ADD, OP_ADC: v = a + b;
                            OP_ORR: v = a | b;
                            OP_MOV: v = b;
                            OP_BIC: v = a & ~b;
                            OP_MVN: v = ~b;
                            default: v = 32'd0;
                        endcase
                        r.reg_write = 1'b1;
                    end
                end
                FMT_MEM: begin
                    ix = IDX_W'(w[11:2] % WORDS_PER_BASE);
                    if (w[25:20] == MEM_LDR) begin
                        v = mem[rn][ix];
                        r.reg_write = 1'b1;
                    end else if (w[25:20] == MEM_STR) begin
                        mem[rn][ix] = regs[rd];
                        r.store_write = 1'b1;
                    end
                end
                FMT_BRANCH: begin
                    if (w[25:24] == BR_CODE && cond_holds(w[31:28])) begin
                        off = {{8{w[23]}}, w[23:0]};
                        regs[PC_INDEX] = regs[PC_INDEX] + 32'd4 + (off << 2);
                    end
                end
                default: begin
                    stopped = 1'b1;
                    r.halted = 1'b1;
                end
            endcase
            if (r.reg_write) begin
                regs[rd] = v;
                r.reg_index = rd;
                r.reg_value = v;
            end
        end
        r.next_pc = regs[PC_INDEX];
        return r;
    endfunction

    // Sends one word, holding valid until the handshake; the expectation is
    // queued at acceptance. A fixed expectation, if given, is checked too.
    // Valid stays high between back-to-back words and drops only to idle.
    task automatic send_word(input logic [31:0] w, input logic chk = 1'b0,
                             input retire_t fixed = '0);
        retire_t exp_word;
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_instr_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_word = execute_word(w);
        if (chk && (exp_word !== fixed))
            report("fixed word next_pc", exp_word.next_pc, fixed.next_pc);
        retire_q.push_back(exp_word);
    endtask

    // Receiver side: random ready, compare on each accepted word.
    always @(posedge aclk) begin
        retire_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (retire_q.size() == 0) begin
                    report("unexpected word next_pc", m_next_pc, 32'd0);
                end else begin
                    want = retire_q.pop_front();
                    if (m_next_pc !== want.next_pc)
                        report("next_pc", m_next_pc, want.next_pc);
                    if (m_reg_write !== want.reg_write)
                        report("reg_write", 32'(m_reg_write), 32'(want.reg_write));
                    if (m_reg_index !== want.reg_index)
                        report("reg_index", 32'(m_reg_index), 32'(want.reg_index));
                    if (m_reg_value !== want.reg_value)
                        report("reg_value", m_reg_value, want.reg_value);
                    if (m_store_write !== want.store_write)
                        report("store_write", 32'(m_store_write),
                               32'(want.store_write));
                    if (m_halted !== want.halted)
                        report("halted", 32'(m_halted), 32'(want.halted));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: cycles with no handshake on either side. Covers the store
    // sweep after reset and the longest random stalls with a wide margin.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 60000) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Builder for well-formed data words.
    function automatic logic [31:0] dp_word(input logic [3:0] op, input logic imm,
                                           input logic [3:0] rn, input logic [3:0] rd,
                                           input logic [11:0] low);
        return {$urandom_range(15) == 0 ? 4'($urandom) : 4'd14, FMT_DATA, imm, op,
                1'($urandom), rn, rd, low};
    endfunction

    // Random word, mostly well formed; small registers so values get reused.
    function automatic logic [31:0] rand_word();
        int sel;
        logic [3:0] rn, rd;
        sel = $urandom_range(99);
        rn = ($urandom_range(9) == 0) ? PC_INDEX : 4'($urandom_range(7));
        rd = ($urandom_range(15) == 0) ? PC_INDEX : 4'($urandom_range(7));
        if (sel < 55)
            return dp_word(4'($urandom), 1'($urandom), rn, rd,
                           ($urandom_range(3) == 0) ? 12'($urandom) :
                           {8'($urandom), 4'($urandom_range(7))});
        if (sel < 80)
            return {4'($urandom), FMT_MEM,
                    ($urandom_range(7) == 0) ? 6'($urandom) :
                    (($urandom_range(1) == 0) ? MEM_LDR : MEM_STR),
                    4'($urandom_range(3)), rd,
                    ($urandom_range(1) == 0) ? 12'($urandom_range(31)) : 12'($urandom)};
        if (sel < 97)
            return {($urandom_range(5) == 0) ? 4'($urandom) :
                    4'($urandom_range(14)), FMT_BRANCH,
                    ($urandom_range(7) == 0) ? 2'($urandom) : BR_CODE,
                    ($urandom_range(3) == 0) ? 24'($urandom) :
                    24'($signed(8'($urandom)))};
        return $urandom & 32'hF3FF_FFFF;   // any data-format noise
    endfunction

    // Directed words: extremes, every operation and each special case.
    localparam int DIR_N = 24;
    logic [31:0] directed [DIR_N] = '{
        {4'd14, FMT_DATA, 1'b1, OP_MVN, 1'b0, 4'd0, 4'd1, 12'h0FF}, // r1 = ~0xFF
        {4'd14, FMT_DATA, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd2, 12'h0FF}, // r2 = 0xFF
        {4'd14, FMT_DATA, 1'b0, OP_AND, 1'b0, 4'd1, 4'd3, 12'h002},
        {4'd14, FMT_DATA, 1'b0, OP_XOR, 1'b0, 4'd1, 4'd3, 12'h002},
        {4'd14, FMT_DATA, 1'b0, OP_SUB, 1'b0, 4'd2, 4'd4, 12'h001},
        {4'd14, FMT_DATA, 1'b0, OP_RSB, 1'b0, 4'd2, 4'd4, 12'h001},
        {4'd14, FMT_DATA, 1'b0, OP_ADD, 1'b0, 4'd1, 4'd5, 12'h001},
        {4'd14, FMT_DATA, 1'b1, OP_ADC, 1'b0, 4'd15, 4'd5, 12'h0FF},
        {4'd14, FMT_DATA, 1'b0, OP_SBC, 1'b0, 4'd0, 4'd6, 12'h001},
        {4'd14, FMT_DATA, 1'b0, OP_RSC, 1'b0, 4'd0, 4'd6, 12'h001},
        {4'd14, FMT_DATA, 1'b0, OP_ORR, 1'b0, 4'd1, 4'd7, 12'h002},
        {4'd14, FMT_DATA, 1'b0, OP_BIC, 1'b0, 4'd1, 4'd7, 12'h002},
        {4'd14, FMT_DATA, 1'b0, 4'd9, 1'b1, 4'd1, 4'd8, 12'h002},     // unassigned op
        {4'd14, FMT_DATA, 1'b0, OP_CMP, 1'b0, 4'd1, 4'd0, 12'h002},   // signed less
        {COND_LT, FMT_BRANCH, BR_CODE, 24'h000001},
        {4'd14, FMT_DATA, 1'b1, OP_CMP, 1'b0, 4'd1, 4'd0, 12'h0FF},   // unsigned greater
        {COND_GT, FMT_BRANCH, BR_CODE, 24'hFFFFFF},
        {4'd14, FMT_MEM, MEM_STR, 4'd3, 4'd1, 12'hFFF},               // highest index
        {4'd14, FMT_MEM, MEM_LDR, 4'd3, 4'd9, 12'hFFC},
        {4'd14, FMT_MEM, 6'd63, 4'd3, 4'd9, 12'h000},                 // other mem op
        {COND_AL, FMT_BRANCH, 2'd3, 24'h7FFFFF},                      // bad branch code
        {4'd15, FMT_BRANCH, BR_CODE, 24'h800000},                     // unlisted cond
        {4'd14, FMT_DATA, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd15, 12'h040},  // pc write
        {COND_AL, FMT_BRANCH, BR_CODE, 24'h800000}                    // long back jump
    };

    task automatic drain();
        s_valid <= 1'b0;
        while (retire_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            regs[i] = 32'd0;
            for (int j = 0; j < WORDS_PER_BASE; j++) mem[i][j] = 32'd0;
        end
        lt_flag = 1'b0;
        eq_flag = 1'b0;
        stopped = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // The first word after reset has a fixed, obvious result:
        // counter 4, register 0 written with 0xFF.
        send_word({4'd14, FMT_DATA, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd0, 12'h0FF},
                  1'b1, {32'd4, 1'b1, 4'd0, 32'h0000_00FF, 1'b0, 1'b0});
        for (int i = 0; i < DIR_N; i++) send_word(directed[i]);
        drain();

        // Three idling phases, each a stream of random words.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 11 : (ph == 1) ? 81 : 0;
            recv_idle = (ph == 0) ? 81 : (ph == 1) ? 11 : 0;
            for (int n = 0; n < 490; n++) begin
                if (n == 200) drain();   // sender waits for every result
                send_word(rand_word());
            end
        end
        recv_idle = 0;
        drain();

        // Halt, then words that must be ignored.
        send_word({4'($urandom), FMT_HALT, 26'($urandom)});
        for (int n = 0; n < 10; n++) send_word($urandom);
        drain();

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/rsie_pkg.sv
hdl/rsie_front.sv
hdl/rsie_back.sv
hdl/risc_subset_instruction_execute_unit.sv
bench/tb.sv
